// ===== rtl/core/button_click_hold_classifier_core_macros.svh =====
// Assertion macros shared by the classifier core.
`ifndef BUTTON_CLICK_HOLD_CLASSIFIER_CORE_MACROS_SVH
`define BUTTON_CLICK_HOLD_CLASSIFIER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BCHC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BCHC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bchc_pkg.sv =====
// Shared types and constants for the button click / hold classifier.
package bchc_pkg;

  localparam int TimeW = 32;

  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_PUSHED = 3'd1;
  localparam logic [2:0] EV_CLICK  = 3'd2;
  localparam logic [2:0] EV_DOUBLE = 3'd3;
  localparam logic [2:0] EV_HOLD   = 3'd4;

  localparam logic [7:0]  DEBOUNCE_RST = 8'd20;
  localparam logic [15:0] DCLICK_RST   = 16'd300;
  localparam logic [15:0] HOLD_RST     = 16'd1000;
  localparam logic        RELEASED_RST = 1'b1;

  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_DCLICK   = 2'd1,
    REG_HOLD     = 2'd2,
    REG_RELEASED = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic             pin_level;
    logic [TimeW-1:0] now_ms;
    logic             clear_latched;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [2:0] latched_event;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  debounce_ms;
    logic [15:0] double_click_window_ms;
    logic [15:0] hold_ms;
    logic        released_level;
  } cfg_t;

endpackage

// ===== rtl/core/bchc_cfg.sv =====
// Configuration register file of the classifier.
module bchc_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [1:0]    wr_index,
  input  logic [15:0]   wr_data,
  output bchc_pkg::cfg_t cfg
);
  import bchc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms            <= DEBOUNCE_RST;
      cfg.double_click_window_ms <= DCLICK_RST;
      cfg.hold_ms                <= HOLD_RST;
      cfg.released_level         <= RELEASED_RST;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_DEBOUNCE: cfg.debounce_ms            <= wr_data[7:0];
        REG_DCLICK:   cfg.double_click_window_ms <= wr_data;
        REG_HOLD:     cfg.hold_ms                <= wr_data;
        REG_RELEASED: cfg.released_level         <= wr_data[0];
      endcase
    end
  end

endmodule

// ===== rtl/core/bchc_classify.sv =====
// Press tracking state and per-sample event classification.
module bchc_classify (
  input  logic                clk,
  input  logic                rst,
  input  bchc_pkg::cfg_t      cfg,
  input  logic                step,
  input  bchc_pkg::in_item_t  item,
  output bchc_pkg::out_item_t result
);
  import bchc_pkg::*;

  logic             held_down;
  logic             held_down_next;
  logic [TimeW-1:0] press_start_ms;
  logic [TimeW-1:0] press_start_ms_next;
  logic [TimeW-1:0] last_click_ms;
  logic [TimeW-1:0] last_click_ms_next;
  logic [2:0]       pending_event;
  logic [2:0]       pending_event_next;

  logic [TimeW-1:0] dur;
  logic [TimeW-1:0] window;
  logic [TimeW-1:0] window_end;
  logic             released;
  logic [2:0]       ev_raw;
  logic [2:0]       ev;
  logic [2:0]       latched;

  assign dur        = item.now_ms - press_start_ms;
  assign window     = {16'd0, cfg.double_click_window_ms};
  assign window_end = last_click_ms + window;
  assign released   = (item.pin_level == cfg.released_level);

  always_comb begin
    ev_raw              = EV_NONE;
    held_down_next      = held_down;
    press_start_ms_next = press_start_ms;
    if (released) begin
      if (held_down) begin
        held_down_next = 1'b0;
        if (dur > {24'd0, cfg.debounce_ms}) ev_raw = EV_CLICK;
        // hold wins even when its threshold sits below debounce
        if (dur > {16'd0, cfg.hold_ms}) ev_raw = EV_HOLD;
      end
    end else if (!held_down) begin
      held_down_next      = 1'b1;
      press_start_ms_next = item.now_ms;
      ev_raw              = EV_PUSHED;
    end
  end

  always_comb begin
    ev                 = ev_raw;
    last_click_ms_next = last_click_ms;
    if (ev_raw == EV_CLICK) begin
      if (window_end < item.now_ms) begin
        last_click_ms_next = item.now_ms;
      end else begin
        // pull the mark back so a third click needs a fresh window
        last_click_ms_next = item.now_ms - window;
        ev                 = EV_DOUBLE;
      end
    end
  end

  assign latched            = (pending_event == EV_NONE) ? ev : pending_event;
  assign pending_event_next = item.clear_latched ? EV_NONE : latched;

  assign result.event_res     = ev;
  assign result.latched_event = latched;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_down      <= 1'b0;
      press_start_ms <= '0;
      last_click_ms  <= '0;
      pending_event  <= EV_NONE;
    end else if (step) begin
      held_down      <= held_down_next;
      press_start_ms <= press_start_ms_next;
      last_click_ms  <= last_click_ms_next;
      pending_event  <= pending_event_next;
    end
  end

endmodule

// ===== rtl/core/button_click_hold_classifier_core.sv =====
// An accepted request passes the input register (item_q), then the result register (out_item).
// Throughput: one sample per cycle unless the output stalls; the input register
// hands a sample to the classifier state in the same cycle the result register loads.
// A stalled output keeps one sample parked in the input register.
// Reset (rst, synchronous): pipeline empty, press state cleared, registers
// take their defaults 20 / 300 / 1000 / released level 1.
module button_click_hold_classifier_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bchc_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output bchc_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import bchc_pkg::*;
  `include "button_click_hold_classifier_core_macros.svh"

  cfg_t      cfg;
  in_item_t  item_q;
  logic      item_valid;
  logic      advance;
  out_item_t result;

  assign cfg_ready = 1'b1;
  assign advance   = item_valid && (!out_valid || out_ready);
  assign in_ready  = !item_valid || advance;

  bchc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  bchc_classify u_classify (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (advance),
    .item   (item_q),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

  `BCHC_ASSERT_NEXT(a_item_kept, item_valid && !advance, item_valid, "parked sample lost")
  `BCHC_ASSERT_NEXT(a_result_loaded, advance, out_valid, "advanced sample gave no result")
  `BCHC_ASSERT_NOW(a_latch_first, out_valid && out_item.latched_event == EV_NONE, out_item.event_res == EV_NONE, "event not latched")

endmodule
